// ----- hdl/circular_double_ended_queue_macros.svh -----
// Assertion helpers shared by the queue modules.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define CDEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset
`define CDEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CDEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CDEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/cdeq_pkg.sv -----
`timescale 1ns / 1ps

package cdeq_pkg;

    localparam int CDEQ_DEPTH = 16;
    localparam int DATA_W     = 32;
    localparam int SIZE_W     = 5;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic exec;
        logic cfg_we;
    } ctrl_cmd_t;

endpackage

// ----- hdl/circular_double_ended_queue.sv -----
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit words in a circular store of DEPTH
// entries, of which cfg_data (1..DEPTH, written while idle) are in use.
// An item is taken when start is high and busy is low; its result (status
// and pop_data) appears on the cycle after, marked by done for exactly one
// cycle, and must be captured then since the receiver cannot stall it.
// Busy stays high during the result cycle and the next item is accepted
// on the cycle after, as the controller takes no new item while a result
// is shown. A register write offered in the same cycle as an item waits
// until the item is done.
module circular_double_ended_queue #(
    parameter int DEPTH = cdeq_pkg::CDEQ_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cdeq_pkg::CMD_W-1:0]          command,
    input  logic signed [cdeq_pkg::DATA_W-1:0]  push_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cdeq_pkg::SIZE_W-1:0]         cfg_data,
    output logic                                done,
    output logic [cdeq_pkg::STATUS_W-1:0]       status,
    output logic signed [cdeq_pkg::DATA_W-1:0]  pop_data
);
    import cdeq_pkg::*;

    ctrl_cmd_t cmd;

    cdeq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .busy      (busy),
        .done      (done),
        .cmd       (cmd)
    );

    cdeq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_data  (cfg_data),
        .command   (command),
        .push_data (push_data),
        .status    (status),
        .pop_data  (pop_data)
    );

endmodule

// ----- hdl/cdeq_ctrl.sv -----
`timescale 1ns / 1ps
`include "circular_double_ended_queue_macros.svh"

module cdeq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    output logic              busy,
    output logic              done,
    output cdeq_pkg::ctrl_cmd_t cmd
);
    import cdeq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    // Accept an item or a register write only while idle; an item offered
    // in the same cycle holds the register write off
    assign cmd.exec   = start && !busy_reg;
    assign cfg_ready  = !busy_reg && !start;
    assign cmd.cfg_we = cfg_valid && !busy_reg && !start;
    assign busy       = busy_reg;
    assign done       = done_reg;

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_RESP;
                        busy_reg  <= 1'b1;
                        done_reg  <= 1'b1;
                    end
                end
                ST_RESP:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    `CDEQ_ASSERT_NXT(a_accept_done, clk, rst_n, cmd.exec, done_reg && busy_reg)
    `CDEQ_ASSERT_NXT(a_done_once, clk, rst_n, done_reg, !done_reg && !busy_reg)
    `CDEQ_ASSERT_IMP(a_busy_state, clk, rst_n, busy_reg, state_reg == ST_RESP)

endmodule

// ----- hdl/cdeq_datapath.sv -----
`timescale 1ns / 1ps
`include "circular_double_ended_queue_macros.svh"

module cdeq_datapath #(
    parameter int DEPTH = cdeq_pkg::CDEQ_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cdeq_pkg::ctrl_cmd_t                 cmd,
    input  logic [cdeq_pkg::SIZE_W-1:0]         cfg_data,
    input  logic [cdeq_pkg::CMD_W-1:0]          command,
    input  logic signed [cdeq_pkg::DATA_W-1:0]  push_data,
    output logic [cdeq_pkg::STATUS_W-1:0]       status,
    output logic signed [cdeq_pkg::DATA_W-1:0]  pop_data
);
    import cdeq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SZ_W  = (IDX_W + 1 > SIZE_W) ? IDX_W + 1 : SIZE_W;
    localparam logic [SZ_W-1:0] DEPTH_SZ = SZ_W'(DEPTH);

    logic [SIZE_W-1:0]   size_reg;
    logic [IDX_W-1:0]    front_reg, front_next;
    logic [IDX_W-1:0]    rear_reg, rear_next;
    logic                empty_reg, empty_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                pop_ok_reg, pop_ok_next;
    logic [DATA_W-1:0]   rd_data_reg;
    logic [DATA_W-1:0]   mem [DEPTH];

    logic [SZ_W-1:0]     size_ext;
    logic [SZ_W-1:0]     eff_size;
    logic [IDX_W-1:0]    last_idx;
    logic [IDX_W-1:0]    rear_fwd;
    logic                full;
    logic                is_push;
    logic                mem_we;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    rd_addr;

    function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] i,
                                                   input logic [IDX_W-1:0] last);
        return (i >= last) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] i,
                                                    input logic [IDX_W-1:0] last);
        return (i == '0) ? last : i - 1'b1;
    endfunction

    // Clamp the size in use to 1..DEPTH
    always_comb
    begin
        size_ext = SZ_W'(size_reg);
        if (size_ext == '0)
            eff_size = SZ_W'(1);
        else if (size_ext > DEPTH_SZ)
            eff_size = DEPTH_SZ;
        else
            eff_size = size_ext;
    end

    assign last_idx = IDX_W'(eff_size - SZ_W'(1));
    assign rear_fwd = step_fwd(rear_reg, last_idx);
    assign full     = !empty_reg && (rear_fwd == front_reg);

    // Decide index moves, store write and result for the item
    always_comb
    begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        empty_next  = empty_reg;
        status_next = STATUS_DONE;
        pop_ok_next = 1'b0;
        mem_we      = 1'b0;
        wr_addr     = '0;
        is_push     = 1'b0;
        rd_addr     = (command == CMD_POP_FRONT) ? front_reg : rear_reg;

        case (command) inside
            CMD_PUSH_FRONT, CMD_PUSH_REAR:
            begin
                is_push = 1'b1;
                if (full)
                    status_next = STATUS_FULL;
                else if (empty_reg)
                begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b0;
                    mem_we     = cmd.exec;
                    wr_addr    = '0;
                end
                else if (command == CMD_PUSH_FRONT)
                begin
                    front_next = step_back(front_reg, last_idx);
                    mem_we     = cmd.exec;
                    wr_addr    = front_next;
                end
                else
                begin
                    rear_next = rear_fwd;
                    mem_we    = cmd.exec;
                    wr_addr   = rear_fwd;
                end
            end
            default:
            begin
                if (empty_reg)
                    status_next = STATUS_EMPTY;
                else
                begin
                    pop_ok_next = 1'b1;
                    if (front_reg == rear_reg)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                        empty_next = 1'b1;
                    end
                    else if (command == CMD_POP_FRONT)
                        front_next = step_fwd(front_reg, last_idx);
                    else
                        rear_next = step_back(rear_reg, last_idx);
                end
            end
        endcase
    end

    // Update indices, size register and result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= SIZE_RESET;
            front_reg  <= '0;
            rear_reg   <= '0;
            empty_reg  <= 1'b1;
            status_reg <= STATUS_DONE;
            pop_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_we)
                size_reg <= cfg_data;
            if (cmd.exec)
            begin
                front_reg  <= front_next;
                rear_reg   <= rear_next;
                empty_reg  <= empty_next;
                status_reg <= status_next;
                pop_ok_reg <= pop_ok_next;
            end
        end
    end

    // Entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= push_data;
        if (cmd.exec)
            rd_data_reg <= mem[rd_addr];
    end

    assign status   = status_reg;
    assign pop_data = pop_ok_reg ? $signed(rd_data_reg) : '0;

    `CDEQ_ASSERT_IMP(a_empty_idx, clk, rst_n, empty_reg, front_reg == '0 && rear_reg == '0)
    `CDEQ_ASSERT_NXT(a_push_full, clk, rst_n, cmd.exec && is_push && full, status_reg == STATUS_FULL)
    `CDEQ_ASSERT_NXT(a_pop_empty, clk, rst_n, cmd.exec && !is_push && empty_reg, status_reg == STATUS_EMPTY && !pop_ok_reg)

endmodule

// ----- tb/deque_checker.sv -----
`timescale 1ns / 1ps

module deque_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [cdeq_pkg::CMD_W-1:0]          command,
    input  logic signed [cdeq_pkg::DATA_W-1:0]  push_data,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [cdeq_pkg::SIZE_W-1:0]         cfg_data,
    input  logic                                done,
    input  logic [cdeq_pkg::STATUS_W-1:0]       status,
    input  logic signed [cdeq_pkg::DATA_W-1:0]  pop_data,
    output int                                  fail_count,
    output int                                  pending
);

    import cdeq_pkg::*;

    localparam int IDX_W = $clog2(CDEQ_DEPTH);

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] pop_data;
    } deque_result_t;

    // Shadow copy of the queue
    logic [SIZE_W-1:0]        size_reg;
    logic signed [DATA_W-1:0] word_mem [CDEQ_DEPTH];
    logic [IDX_W-1:0]         head_idx;
    logic [IDX_W-1:0]         tail_idx;
    logic                     is_empty;

    deque_result_t awaited_results[$];

    // Clamp the programmed size to 1..DEPTH
    function automatic int live_size();
        int n;
        n = int'(size_reg);
        if (n < 1) n = 1;
        if (n > CDEQ_DEPTH) n = CDEQ_DEPTH;
        return n;
    endfunction

    // Step forward; any index at or past the last live slot wraps to 0
    function automatic logic [IDX_W-1:0] wrap_up(logic [IDX_W-1:0] i, int n);
        return (int'(i) >= n - 1) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_down(logic [IDX_W-1:0] i, int n);
        return (i == '0) ? IDX_W'(n - 1) : i - 1'b1;
    endfunction

    // Apply one command to the shadow queue and return its outcome
    function automatic deque_result_t run_command(logic [CMD_W-1:0] cmd,
                                                  logic signed [DATA_W-1:0] word);
        deque_result_t r;
        int n;
        logic full;
        n = live_size();
        r.status = STATUS_DONE;
        r.pop_data = '0;
        if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) begin
            full = !is_empty && (wrap_up(tail_idx, n) == head_idx);
            if (full) begin
                r.status = STATUS_FULL;
            end else if (is_empty) begin
                head_idx = '0;
                tail_idx = '0;
                is_empty = 1'b0;
                word_mem[0] = word;
            end else if (cmd == CMD_PUSH_FRONT) begin
                head_idx = wrap_down(head_idx, n);
                word_mem[head_idx] = word;
            end else begin
                tail_idx = wrap_up(tail_idx, n);
                word_mem[tail_idx] = word;
            end
        end else if (is_empty) begin
            r.status = STATUS_EMPTY;
        end else begin
            r.pop_data = (cmd == CMD_POP_FRONT) ? word_mem[head_idx] : word_mem[tail_idx];
            if (head_idx == tail_idx) begin
                // last entry out: back to the empty state
                head_idx = '0;
                tail_idx = '0;
                is_empty = 1'b1;
            end else if (cmd == CMD_POP_FRONT) begin
                head_idx = wrap_up(head_idx, n);
            end else begin
                tail_idx = wrap_down(tail_idx, n);
            end
        end
        return r;
    endfunction

    // Watch the channels: check results, predict accepted items, track the size
    always @(posedge clk or negedge rst_n) begin
        deque_result_t want;
        if (!rst_n) begin
            size_reg = SIZE_RESET;
            head_idx = '0;
            tail_idx = '0;
            is_empty = 1'b1;
            awaited_results.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (done) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: status %0d pop_data %0d", status, pop_data);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (pop_data !== want.pop_data) begin
                        $error("pop_data: expected %0d, actual %0d", want.pop_data, pop_data);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                awaited_results.push_back(run_command(command, push_data));
            end
            if (cfg_valid && cfg_ready) begin
                size_reg = cfg_data;
            end
            pending = awaited_results.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import cdeq_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_COUNT  = 12;
    localparam int PHASE_ITEMS  = 38;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] push_data;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [SIZE_W-1:0]        cfg_data;
    logic                     done;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] pop_data;

    int fail_count;
    int pending;
    int burst_left = 0;
    int idle_cycles = 0;

    circular_double_ended_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .push_data (push_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .status    (status),
        .pop_data  (pop_data)
    );

    deque_checker deque_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .push_data  (push_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .done       (done),
        .status     (status),
        .pop_data   (pop_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || done) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Favor the boundary words now and then
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(7, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Drive one item and hold it until taken; returns on a falling edge
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] word);
        if (burst_left == 0) begin
            start = 1'b0;
            repeat ($urandom_range(12, 1)) @(negedge clk);
            burst_left = $urandom_range(24, 1);
        end
        start = 1'b1;
        command = cmd;
        push_data = word;
        do @(posedge clk); while (busy);
        @(negedge clk);
        burst_left--;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        start = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] value);
        drain();
        cfg_valid = 1'b1;
        cfg_data = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        logic [SIZE_W-1:0] phase_size;
        int push_pct;
        start = 1'b0;
        command = CMD_PUSH_FRONT;
        push_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Pops on an empty queue are refused
        send_command(CMD_POP_FRONT, 32'h1234_5678);
        send_command(CMD_POP_REAR, 32'hffff_ffff);

        // Fill all sixteen entries, so every slot holds a written word
        send_command(CMD_PUSH_REAR, 32'h7fff_ffff);
        send_command(CMD_PUSH_FRONT, 32'h8000_0000);
        send_command(CMD_PUSH_REAR, 32'h0000_0000);
        send_command(CMD_PUSH_FRONT, 32'hffff_ffff);
        for (int i = 0; i < 12; i++) begin
            send_command((i % 2 == 0) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, $urandom);
        end

        // Full queue refuses both pushes
        send_command(CMD_PUSH_FRONT, 32'h5555_5555);
        send_command(CMD_PUSH_REAR, 32'haaaa_aaaa);
        send_command(CMD_POP_FRONT, 32'h0);
        send_command(CMD_POP_REAR, 32'h0);

        // Random phases over several sizes, the queue kept live across changes
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0:       phase_size = 5'd1;
                1:       phase_size = 5'd2;
                2:       phase_size = 5'd0;
                3:       phase_size = 5'd31;
                4:       phase_size = 5'd5;
                5:       phase_size = 5'd16;
                6:       phase_size = 5'd17;
                7:       phase_size = 5'd3;
                10:      phase_size = 5'd8;
                11:      phase_size = 5'd16;
                default: phase_size = SIZE_W'($urandom_range(31, 0));
            endcase
            write_size(phase_size);
            push_pct = 25 * $urandom_range(3, 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // swing the mix halfway so both full and empty are reached
                if (k == PHASE_ITEMS / 2) push_pct = 100 - push_pct;
                if ($urandom_range(63, 0) == 0) drain();
                if ($urandom_range(99, 0) < push_pct) begin
                    send_command($urandom_range(1, 0) ? CMD_PUSH_REAR : CMD_PUSH_FRONT,
                                 pick_word());
                end else begin
                    send_command($urandom_range(1, 0) ? CMD_POP_REAR : CMD_POP_FRONT,
                                 $urandom);
                end
            end
        end

        drain();
        repeat (5) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
